FILE: src/lgmn_pkg.sv
package lgmn_pkg;

  localparam int GRID_DIM_DEF = 8;
  localparam int GRID_DIM_MIN = 3;
  localparam int GRID_DIM_MAX = 8;

  localparam logic [7:0] HOST_ADDR = 8'hFF;

  localparam logic REG_NODE_X = 1'b0;
  localparam logic REG_NODE_Y = 1'b1;

  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_GENERATION = 1'b1;

  typedef logic [7:0] byte_t;

endpackage

FILE: src/lgmn_cell_unit.sv
module lgmn_cell_unit #(
  parameter int GRID_DIM = lgmn_pkg::GRID_DIM_DEF,
  localparam int CELLS = GRID_DIM * GRID_DIM,
  localparam int RC_W = $clog2(GRID_DIM)
) (
  input  logic [CELLS-1:0] cells_nz,
  input  logic             cur_one,
  input  logic [RC_W-1:0]  row,
  input  logic [RC_W-1:0]  col,
  output logic             next_alive
);

  logic       top_ok;
  logic       bot_ok;
  logic       lft_ok;
  logic       rgt_ok;
  logic [7:0] taps;
  logic [1:0] sum_a, sum_b, sum_c, sum_d;
  logic [2:0] sum_ab, sum_cd;
  logic [3:0] nb_count;

  assign top_ok = (row != '0);
  assign bot_ok = (row != RC_W'(GRID_DIM - 1));
  assign lft_ok = (col != '0);
  assign rgt_ok = (col != RC_W'(GRID_DIM - 1));

  assign taps[0] = top_ok && lft_ok && cells_nz[CELLS-GRID_DIM-1];
  assign taps[1] = top_ok && cells_nz[CELLS-GRID_DIM];
  assign taps[2] = top_ok && rgt_ok && cells_nz[CELLS-GRID_DIM+1];
  assign taps[3] = lft_ok && cells_nz[CELLS-1];
  assign taps[4] = rgt_ok && cells_nz[1];
  assign taps[5] = bot_ok && lft_ok && cells_nz[GRID_DIM-1];
  assign taps[6] = bot_ok && cells_nz[GRID_DIM];
  assign taps[7] = bot_ok && rgt_ok && cells_nz[GRID_DIM+1];

  assign sum_a = {1'b0, taps[0]} + {1'b0, taps[1]};
  assign sum_b = {1'b0, taps[2]} + {1'b0, taps[3]};
  assign sum_c = {1'b0, taps[4]} + {1'b0, taps[5]};
  assign sum_d = {1'b0, taps[6]} + {1'b0, taps[7]};
  assign sum_ab = {1'b0, sum_a} + {1'b0, sum_b};
  assign sum_cd = {1'b0, sum_c} + {1'b0, sum_d};
  assign nb_count = {1'b0, sum_ab} + {1'b0, sum_cd};

  always_comb begin
    if (cur_one) begin
      next_alive = (nb_count == 4'd2) || (nb_count == 4'd3);
    end else begin
      next_alive = (nb_count == 4'd3);
    end
  end

endmodule

FILE: src/life_grid_mesh_node.sv
// Channel  | Ports                                   | Handshake
// request  | in_req_type, in_pkt_*                   | start & !busy
// result   | out_dest_*, out_cell_*, out_last        | out_valid, one cycle, no stall
// config   | cfg_index, cfg_wdata                    | cfg_we
//
// A packet request is handled in the cycle it is accepted; a forwarded packet appears the next cycle.
// A generation request walks the grid one cell per cycle through the shared
// neighbor unit with busy high, then the grid is replaced.
// At node (0,0) each cell's new value leaves in the cycle after it is computed.
// Synchronous active-low reset clears the grid, coordinates and sequencer.
// The receiver cannot stall; results are never held.
module life_grid_mesh_node #(
  parameter int GRID_DIM = lgmn_pkg::GRID_DIM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_req_type,
  input  logic [7:0] in_pkt_dest_x,
  input  logic [7:0] in_pkt_dest_y,
  input  logic [7:0] in_pkt_cell_value,
  input  logic [7:0] in_pkt_cell_index,
  output logic       out_valid,
  output logic [7:0] out_dest_x,
  output logic [7:0] out_dest_y,
  output logic [7:0] out_cell_value,
  output logic [7:0] out_cell_index,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int CELLS = GRID_DIM * GRID_DIM;
  localparam int CIDX_W = $clog2(CELLS);
  localparam int RC_W = $clog2(GRID_DIM);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_GEN = 1'b1;

  logic                 state_r, state_nxt;
  lgmn_pkg::byte_t      node_x_r, node_y_r;
  logic [CELLS-1:0]     grid_nz_r, grid_nz_nxt;
  logic [CELLS-1:0]     grid_one_r, grid_one_nxt;
  logic [CELLS-1:0]     next_r, next_nxt;
  logic [CIDX_W-1:0]    idx_r, idx_nxt;
  logic [RC_W-1:0]      row_r, row_nxt;
  logic [RC_W-1:0]      col_r, col_nxt;
  logic                 to_host_r, to_host_nxt;
  logic                 out_valid_r, out_valid_nxt;
  lgmn_pkg::byte_t      out_dx_r, out_dx_nxt;
  lgmn_pkg::byte_t      out_dy_r, out_dy_nxt;
  lgmn_pkg::byte_t      out_val_r, out_val_nxt;
  lgmn_pkg::byte_t      out_idx_r, out_idx_nxt;
  logic                 out_last_r, out_last_nxt;

  logic accept;
  logic pkt_empty;
  logic pkt_mine;
  logic last_cell;
  logic cell_next;

  lgmn_cell_unit #(.GRID_DIM(GRID_DIM)) u_cell (
    .cells_nz  (grid_nz_r),
    .cur_one   (grid_one_r[0]),
    .row       (row_r),
    .col       (col_r),
    .next_alive(cell_next)
  );

  assign busy = (state_r == ST_GEN);
  assign accept = start && !busy;
  assign pkt_empty = (in_pkt_dest_x == 8'd0) && (in_pkt_dest_y == 8'd0) &&
                     (in_pkt_cell_value == 8'd0) && (in_pkt_cell_index == 8'd0);
  assign pkt_mine = (in_pkt_dest_x == node_x_r) && (in_pkt_dest_y == node_y_r);
  assign last_cell = (idx_r == CIDX_W'(CELLS - 1));

  always_comb begin
    state_nxt = state_r;
    grid_nz_nxt = grid_nz_r;
    grid_one_nxt = grid_one_r;
    next_nxt = next_r;
    idx_nxt = idx_r;
    row_nxt = row_r;
    col_nxt = col_r;
    to_host_nxt = to_host_r;
    out_valid_nxt = 1'b0;
    out_dx_nxt = out_dx_r;
    out_dy_nxt = out_dy_r;
    out_val_nxt = out_val_r;
    out_idx_nxt = out_idx_r;
    out_last_nxt = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == lgmn_pkg::REQ_GENERATION) begin
            state_nxt = ST_GEN;
            idx_nxt = '0;
            row_nxt = '0;
            col_nxt = '0;
            to_host_nxt = (node_x_r == 8'd0) && (node_y_r == 8'd0);
          end else if (!pkt_empty) begin
            if (pkt_mine) begin
              if (in_pkt_cell_index < 8'(CELLS)) begin
                grid_nz_nxt[in_pkt_cell_index[CIDX_W-1:0]] = (in_pkt_cell_value != 8'd0);
                grid_one_nxt[in_pkt_cell_index[CIDX_W-1:0]] = (in_pkt_cell_value == 8'd1);
              end
            end else begin
              out_valid_nxt = 1'b1;
              out_dx_nxt = in_pkt_dest_x;
              out_dy_nxt = in_pkt_dest_y;
              out_val_nxt = in_pkt_cell_value;
              out_idx_nxt = in_pkt_cell_index;
              out_last_nxt = 1'b1;
            end
          end
        end
      end
      ST_GEN: begin
        // rotate the grid so the current cell stays at bit 0
        grid_nz_nxt = {grid_nz_r[0], grid_nz_r[CELLS-1:1]};
        grid_one_nxt = {grid_one_r[0], grid_one_r[CELLS-1:1]};
        next_nxt = {cell_next, next_r[CELLS-1:1]};
        out_valid_nxt = to_host_r;
        out_dx_nxt = lgmn_pkg::HOST_ADDR;
        out_dy_nxt = lgmn_pkg::HOST_ADDR;
        out_val_nxt = {7'd0, cell_next};
        out_idx_nxt = 8'(idx_r);
        out_last_nxt = last_cell;
        idx_nxt = idx_r + 1'b1;
        if (col_r == RC_W'(GRID_DIM - 1)) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
        if (last_cell) begin
          // commit the whole generation at once
          grid_nz_nxt = next_nxt;
          grid_one_nxt = next_nxt;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      node_x_r <= 8'd0;
      node_y_r <= 8'd0;
      grid_nz_r <= '0;
      grid_one_r <= '0;
      idx_r <= '0;
      row_r <= '0;
      col_r <= '0;
      to_host_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      grid_nz_r <= grid_nz_nxt;
      grid_one_r <= grid_one_nxt;
      idx_r <= idx_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      to_host_r <= to_host_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == lgmn_pkg::REG_NODE_X)) begin
        node_x_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == lgmn_pkg::REG_NODE_Y)) begin
        node_y_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    next_r <= next_nxt;
    out_dx_r <= out_dx_nxt;
    out_dy_r <= out_dy_nxt;
    out_val_r <= out_val_nxt;
    out_idx_r <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_dest_x = out_dx_r;
  assign out_dest_y = out_dy_r;
  assign out_cell_value = out_val_r;
  assign out_cell_index = out_idx_r;
  assign out_last = out_last_r;

  a_gen_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == lgmn_pkg::REQ_GENERATION)) |=> busy)
    else $error("generation request did not raise busy");

  a_host_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && to_host_r) |=> out_valid)
    else $error("missing host result during generation");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap in generation result stream");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && last_cell) |=> !busy)
    else $error("sequencer did not finish after last cell");

endmodule
